/* hdl/laplacian_edge_filter_rgb_defines.svh */
// Assertion macros for the Laplacian edge filter.
// Clock aclk and active-low reset aresetn are assumed in the asserting module.
`ifndef LAPLACIAN_EDGE_FILTER_RGB_DEFINES_SVH
`define LAPLACIAN_EDGE_FILTER_RGB_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define LEF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LEF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`else

`define LEF_ASSERT_NOW(label, ante, cons, msg)
`define LEF_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* hdl/lef_pkg.sv */
package lef_pkg;

    localparam int PIX_W       = 24;
    localparam int CHAN_W      = 8;
    localparam int COORD_W     = 10;
    localparam int CFG_W       = 11;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 48;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd500;
    localparam logic [CFG_W-1:0] SIZE_MIN   = 11'd3;
    localparam logic [CFG_W-1:0] HEIGHT_MAX = 11'd1024;

    // register index = paddr[2]
    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        pix_t               pix;   // {blue, green, red}
    } result_t;

    // 8*centre minus the eight neighbours, per channel, clamped to 0..255
    function automatic pix_t lap_pix(input pix_t win [9]);
        pix_t              res;
        logic signed [12:0] acc;
        res = '0;
        for (int ch = 0; ch < 3; ch++) begin
            acc = $signed({2'b00, win[4][CHAN_W*ch +: CHAN_W], 3'b000});
            for (int i = 0; i < 9; i++) begin
                if (i != 4) begin
                    acc = acc - $signed({5'b00000, win[i][CHAN_W*ch +: CHAN_W]});
                end
            end
            if (acc < 0) begin
                res[CHAN_W*ch +: CHAN_W] = 8'd0;
            end else if (acc > 13'sd255) begin
                res[CHAN_W*ch +: CHAN_W] = 8'd255;
            end else begin
                res[CHAN_W*ch +: CHAN_W] = acc[CHAN_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

/* hdl/laplacian_edge_filter_rgb.sv */
// Channel  | Dir | Payload                                          | Handshake
// s_       | in  | tdata: red, green, blue; tuser: frame_start      | tvalid/tready
// m_       | out | tdata: red, green, blue, col, row; tlast: last   | tvalid/tready
// APB      | in  | image_width @0x0, image_height @0x4              | pready tied high
//
// One pixel per clock sustained while m_tready is high, but a pixel that yields two
// words (interior result plus a border pixel at line end or bottom row) can stall s_
// while the first is held. An accepted pixel passes stage 1 (line store read), then
// the output stage, a 2-entry holding register for the window/filter result. Line
// stores are 1R1W RAMs. aresetn is synchronous; line stores are not cleared (no sweep).
`include "laplacian_edge_filter_rgb_defines.svh"

module laplacian_edge_filter_rgb #(
    parameter int LINE_DEPTH = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // APB config
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lef_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lef_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lef_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    // pixel in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lef_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    input  logic                            s_tuser,   // [0] frame_start
    // pixel out
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lef_pkg::M_TDATA_W-1:0]   m_tdata,   // [7:0] red, [15:8] green,
                                                       // [23:16] blue, [33:24] pixel_col,
                                                       // [43:34] pixel_row, [47:44] zero
    output logic                            m_tlast    // run_last
);
    import lef_pkg::*;

    localparam int AW   = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int WMAX = (LINE_DEPTH < 1024) ? LINE_DEPTH : 1024;

    // ---------------------------------------------------------------- config
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [CFG_W-1:0] width_use, height_use;
    logic [COORD_W-1:0] wm1, hm1;   // last column / last row in use
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end else if (cfg_wr) begin
            case (reg_idx_t'(paddr[2]))
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx_t'(paddr[2]))
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // clamp to the supported frame size
    always_comb begin
        if (width_reg < SIZE_MIN) begin
            width_use = SIZE_MIN;
        end else if (width_reg > CFG_W'(WMAX)) begin
            width_use = CFG_W'(WMAX);
        end else begin
            width_use = width_reg;
        end
        if (height_reg < SIZE_MIN) begin
            height_use = SIZE_MIN;
        end else if (height_reg > HEIGHT_MAX) begin
            height_use = HEIGHT_MAX;
        end else begin
            height_use = height_reg;
        end
    end

    assign wm1 = COORD_W'(width_use - 11'd1);
    assign hm1 = COORD_W'(height_use - 11'd1);

    // ---------------------------------------------------------------- input / position
    logic               in_acc;
    logic [COORD_W-1:0] col_reg, row_reg, col_next, row_next;
    logic [COORD_W-1:0] c_in, r_in;
    logic               last_col, int_in, bor_in;
    logic [AW-1:0]      addr_in;

    assign in_acc = s_tvalid && s_tready;
    assign c_in   = s_tuser ? '0 : col_reg;
    assign r_in   = s_tuser ? '0 : row_reg;
    assign addr_in = AW'(c_in);

    assign last_col = (c_in >= wm1);
    assign int_in   = (c_in >= 10'd2) && (r_in >= 10'd2) && (c_in <= wm1) && (r_in <= hm1);
    assign bor_in   = (c_in == '0) || last_col || (r_in == '0) || (r_in >= hm1);

    always_comb begin
        if (last_col) begin
            col_next = '0;
            row_next = (r_in >= hm1) ? '0 : r_in + 10'd1;
        end else begin
            col_next = c_in + 10'd1;
            row_next = r_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (in_acc) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------------------------------------------------------- stage 1 regs
    logic               s1_valid_reg;
    pix_t               s1_px_reg;
    logic [COORD_W-1:0] s1_c_reg, s1_r_reg;
    logic               s1_int_reg, s1_bor_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic               s1_adv, out_free;

    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_acc) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            s1_px_reg   <= s_tdata[PIX_W-1:0];
            s1_c_reg    <= c_in;
            s1_r_reg    <= r_in;
            s1_int_reg  <= int_in;
            s1_bor_reg  <= bor_in;
            s1_addr_reg <= addr_in;
        end
    end

    // ---------------------------------------------------------------- line stores
    // Read on accept, write back when the item leaves stage 1. Memory is read-first,
    // so a read of the entry written in the same cycle takes the forwarded value.
    pix_t upper_mem  [LINE_DEPTH];
    pix_t middle_mem [LINE_DEPTH];
    pix_t up_rd_reg, mid_rd_reg;
    pix_t fwd_up_reg, fwd_mid_reg;
    logic fwd_hit_reg;
    pix_t s1_up, s1_mid;

    assign s1_up  = fwd_hit_reg ? fwd_up_reg  : up_rd_reg;
    assign s1_mid = fwd_hit_reg ? fwd_mid_reg : mid_rd_reg;

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            upper_mem[s1_addr_reg] <= s1_mid;
        end
        if (in_acc) begin
            up_rd_reg <= upper_mem[addr_in];
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            middle_mem[s1_addr_reg] <= s1_px_reg;
        end
        if (in_acc) begin
            mid_rd_reg <= middle_mem[addr_in];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (in_acc) begin
            fwd_hit_reg <= s1_adv && (s1_addr_reg == addr_in);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            fwd_up_reg  <= s1_mid;
            fwd_mid_reg <= s1_px_reg;
        end
    end

    // ---------------------------------------------------------------- 3x3 window
    // row-major, top row from the oldest line, right column newest
    pix_t win_reg  [9];
    pix_t win_next [9];
    pix_t lap_res;

    always_comb begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = s1_up;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = s1_mid;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = s1_px_reg;
    end

    assign lap_res = lap_pix(win_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else if (s1_adv) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    // ---------------------------------------------------------------- output stage
    // up to two words per pixel: interior result first, then the border pixel
    result_t res_int, res_bor;
    result_t head_reg, tail_reg;
    logic [1:0] out_cnt_reg;
    logic       out_take;

    assign res_int = '{row: s1_r_reg - 10'd1, col: s1_c_reg - 10'd1, pix: lap_res};
    assign res_bor = '{row: s1_r_reg, col: s1_c_reg, pix: s1_px_reg};

    assign m_tvalid = (out_cnt_reg != 2'd0);
    assign out_take = m_tvalid && m_tready;
    assign out_free = (out_cnt_reg == 2'd0) || ((out_cnt_reg == 2'd1) && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_cnt_reg <= 2'd0;
        end else if (s1_adv) begin
            out_cnt_reg <= {1'b0, s1_int_reg} + {1'b0, s1_bor_reg};
        end else if (out_take) begin
            out_cnt_reg <= out_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            head_reg <= s1_int_reg ? res_int : res_bor;
            tail_reg <= res_bor;
        end else if (out_take) begin
            head_reg <= tail_reg;
        end
    end

    assign m_tdata = {4'b0000, head_reg.row, head_reg.col, head_reg.pix};
    assign m_tlast = (out_cnt_reg == 2'd1);

    // ---------------------------------------------------------------- checks
    `LEF_ASSERT_NOW(a_cnt_range, 1'b1, out_cnt_reg != 2'd3, "output count out of range")
    `LEF_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s1_adv, s1_valid_reg && $stable(s1_c_reg) && $stable(s1_r_reg), "stage 1 item lost while stalled")
    `LEF_ASSERT_NEXT(a_res_shown, s1_adv && (s1_int_reg || s1_bor_reg), m_tvalid, "result not presented")
    `LEF_ASSERT_NEXT(a_tail_kept, out_cnt_reg == 2'd2, m_tvalid, "second word dropped")
    `LEF_ASSERT_NOW(a_ready_cause, !s_tready, s1_valid_reg && m_tvalid, "input stalled without backlog")

endmodule

/* tb/laplacian_edge_filter_rgb_tb.sv */
module laplacian_edge_filter_rgb_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lef_pkg::*;

    localparam int LINE_DEPTH  = 1024;
    localparam int WIDTH_MAX   = (LINE_DEPTH < HEIGHT_MAX) ? LINE_DEPTH : HEIGHT_MAX;
    localparam int CHAN_MAX    = 255;
    localparam int SETTLE_CYC  = 10;   // longer than the accept-to-output path

    // one pixel, channel 0 = red .. channel 2 = blue; matches tdata byte order
    typedef logic [2:0][CHAN_W-1:0] rgb_t;

    typedef struct packed {
        logic fs;
        rgb_t pix;
    } pixel_t;

    typedef struct packed {
        rgb_t               pix;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last_word;
    } edge_word_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;   // [7:0] red, [15:8] green, [23:16] blue
    logic                  s_tuser  = 1'b0; // [0] frame_start
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // [7:0] red, [15:8] green, [23:16] blue,
                                            // [33:24] pixel_col, [43:34] pixel_row
    logic                  m_tlast;         // run_last

    laplacian_edge_filter_rgb #(
        .LINE_DEPTH(LINE_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Filter predictor state: own copy of registers, line stores, window
    // and raster position. Updated once per accepted input word.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    rgb_t               upper_line  [LINE_DEPTH];
    rgb_t               middle_line [LINE_DEPTH];
    rgb_t               window      [9];   // row-major, top row = oldest line
    logic [COORD_W-1:0] col_pos;
    logic [COORD_W-1:0] row_pos;

    pixel_t     pixels_to_send [$];   // stimulus not yet driven
    edge_word_t filtered_due   [$];   // predicted output words, oldest first
    int         mismatches = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;

    // stimulus-side raster tracker, mirrors the block's counters as queued
    int gen_col = 0;
    int gen_row = 0;
    bit need_fs = 1'b1;

    // size in use: register saturated to 3..max
    function automatic int eff_dim(input logic [CFG_W-1:0] v, input int max_dim);
        if (v < SIZE_MIN) return int'(SIZE_MIN);
        if (int'(v) > max_dim) return max_dim;
        return int'(v);
    endfunction

    // 8*centre minus the eight neighbours, per channel, clamped to 0..255
    function automatic rgb_t edge_of_window();
        rgb_t res;
        int   acc;
        for (int ch = 0; ch < 3; ch++) begin
            acc = 8 * int'(window[4][ch]);
            for (int i = 0; i < 9; i++) begin
                if (i != 4) acc -= int'(window[i][ch]);
            end
            if (acc < 0) acc = 0;
            if (acc > CHAN_MAX) acc = CHAN_MAX;
            res[ch] = acc[CHAN_W-1:0];
        end
        return res;
    endfunction

    task automatic filter_pixel(input rgb_t px, input logic fs);
        int         w;
        int         h;
        int         c;
        int         r;
        int         n;
        rgb_t       up;
        rgb_t       mid;
        edge_word_t words [2];
        w = eff_dim(width_reg, WIDTH_MAX);
        h = eff_dim(height_reg, HEIGHT_MAX);
        if (fs) begin
            col_pos = '0;
            row_pos = '0;
        end
        c = int'(col_pos);
        r = int'(row_pos);
        // line stores shift down one line at this column
        up  = upper_line[c];
        mid = middle_line[c];
        upper_line[c]  = mid;
        middle_line[c] = px;
        window[0] = window[1]; window[1] = window[2]; window[2] = up;
        window[3] = window[4]; window[4] = window[5]; window[5] = mid;
        window[6] = window[7]; window[7] = window[8]; window[8] = px;
        n = 0;
        // interior pixel one up, one left is complete now
        if (c >= 2 && r >= 2 && c <= w - 1 && r <= h - 1) begin
            words[n].pix       = edge_of_window();
            words[n].col       = COORD_W'(c - 1);
            words[n].row       = COORD_W'(r - 1);
            words[n].last_word = 1'b0;
            n++;
        end
        // border pixels pass straight through on arrival
        if (c == 0 || c >= w - 1 || r == 0 || r >= h - 1) begin
            words[n].pix       = px;
            words[n].col       = COORD_W'(c);
            words[n].row       = COORD_W'(r);
            words[n].last_word = 1'b0;
            n++;
        end
        if (n > 0) words[n-1].last_word = 1'b1;
        for (int i = 0; i < n; i++) filtered_due.push_back(words[i]);
        // a column at/past the last one ends the line, same for rows
        if (c >= w - 1) begin
            col_pos = '0;
            row_pos = (r >= h - 1) ? '0 : COORD_W'(r + 1);
        end else begin
            col_pos = COORD_W'(c + 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver: next word goes out once the current one is taken.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) filter_pixel(rgb_t'(s_tdata), s_tuser);
            if (!s_tvalid || s_tready) begin
                if (pixels_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    pixel_t nxt;
                    nxt = pixels_to_send.pop_front();
                    s_tdata  <= nxt.pix;
                    s_tuser  <= nxt.fs;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Output monitor: every taken word against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (filtered_due.size() == 0) begin
                    $display("%0t: unexpected output word, expected none got tdata %h tlast %b",
                             $time, m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    edge_word_t want;
                    want = filtered_due.pop_front();
                    check_field("red",       int'(want.pix[0]),  int'(m_tdata[7:0]));
                    check_field("green",     int'(want.pix[1]),  int'(m_tdata[15:8]));
                    check_field("blue",      int'(want.pix[2]),  int'(m_tdata[23:16]));
                    check_field("pixel_col", int'(want.col),     int'(m_tdata[33:24]));
                    check_field("pixel_row", int'(want.row),     int'(m_tdata[43:34]));
                    check_field("run_last",  int'(want.last_word), int'(m_tlast));
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // queue one word and advance the stimulus-side raster position
    task automatic queue_one(input rgb_t px, input bit fs);
        pixel_t item;
        int     w;
        int     h;
        w = eff_dim(width_reg, WIDTH_MAX);
        h = eff_dim(height_reg, HEIGHT_MAX);
        item.pix = px;
        item.fs  = fs;
        pixels_to_send.push_back(item);
        if (fs) begin
            gen_col = 0;
            gen_row = 0;
        end
        if (gen_col >= w - 1) begin
            gen_col = 0;
            gen_row = (gen_row >= h - 1) ? 0 : gen_row + 1;
        end else begin
            gen_col++;
        end
    endtask

    function automatic logic [CHAN_W-1:0] rand_chan(input bit flat, input int base);
        if (flat) return CHAN_W'(base + $urandom_range(0, 15));
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom_range(0, CHAN_MAX));
        endcase
    endfunction

    // mostly clean raster frames; noise_pct adds frame starts mid-frame
    task automatic queue_pixels(input int count, input int noise_pct);
        rgb_t px;
        bit   fs;
        int   base;
        base = $urandom_range(0, 240);
        for (int i = 0; i < count; i++) begin
            fs = 1'b0;
            if (need_fs) begin
                fs      = 1'b1;
                need_fs = 1'b0;
            end else if (gen_col == 0 && gen_row == 0) begin
                fs = ($urandom_range(0, 9) != 0);
            end else if ($urandom_range(0, 99) < noise_pct) begin
                fs = 1'b1;
            end
            // alternate saturating content with flat content for mid-range results
            for (int ch = 0; ch < 3; ch++) px[ch] = rand_chan(((i / 24) % 2) == 1, base);
            queue_one(px, fs);
        end
    endtask

    // block is idle: nothing left to send, nothing in flight
    task automatic settle_idle();
        while (pixels_to_send.size() != 0 || s_tvalid || filtered_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // APB write then read-back; predictor copy follows the write
    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_W'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);   // write lands here; go straight into read setup
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== APB_DATA_W'(val)) begin
            $display("%0t: register %s read expected %0d got %0d",
                     $time, idx.name(), val, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) width_reg = val;
        else                        height_reg = val;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] wr, input logic [CFG_W-1:0] hr,
                             input int count, input int noise_pct,
                             input int s_idle, input int r_idle);
        settle_idle();
        // growing width needs a fresh frame, else unwritten line store is read
        if (eff_dim(wr, WIDTH_MAX) > eff_dim(width_reg, WIDTH_MAX)) need_fs = 1'b1;
        write_reg(REG_IMAGE_WIDTH, wr);
        write_reg(REG_IMAGE_HEIGHT, hr);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        queue_pixels(count, noise_pct);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        rgb_t px;
        width_reg  = WIDTH_RST;
        height_reg = HEIGHT_RST;
        for (int i = 0; i < LINE_DEPTH; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (int i = 0; i < 9; i++) window[i] = '0;
        col_pos = '0;
        row_pos = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset sizes, top row pass-through with all-zero/all-one words
        queue_one('0, 1'b1);
        queue_one('1, 1'b0);
        settle_idle();
        write_reg(REG_IMAGE_WIDTH, SIZE_MIN);
        write_reg(REG_IMAGE_HEIGHT, SIZE_MIN);

        // 3x3 frame: red clamps high, green clamps low, blue lands at 128
        for (int i = 0; i < 9; i++) begin
            px = (i == 4) ? rgb_t'({8'd128, 8'd0, 8'd255}) : rgb_t'({8'd112, 8'd255, 8'd0});
            queue_one(px, i == 0);
        end
        // aborted frame, then a frame start in the middle of a line
        for (int i = 0; i < 4; i++) begin
            for (int ch = 0; ch < 3; ch++) px[ch] = CHAN_W'($urandom_range(0, CHAN_MAX));
            queue_one(px, i == 0);
        end
        // dark centre among bright neighbours: all channels clamp to zero
        for (int i = 0; i < 9; i++) queue_one((i == 4) ? rgb_t'('0) : rgb_t'('1), i == 0);

        // random: sender idles lightly, receiver heavily
        run_phase(11'd3,  11'd3,  40, 3, 17, 74);
        run_phase(11'd0,  11'd1,  30, 3, 17, 74);   // below range: saturates to 3
        run_phase(11'd9,  11'd6,  70, 3, 17, 74);
        run_phase(11'd6,  11'd6,  40, 3, 17, 74);   // narrower mid-line
        // sender idles heavily, receiver lightly
        run_phase(11'd12, 11'd5,  80, 3, 74, 17);
        run_phase(11'd5,  11'd12, 70, 3, 74, 17);
        run_phase(11'd4,  11'd3,  40, 3, 74, 17);
        run_phase(11'd7,  11'd1030, 40, 3, 74, 17); // above range: 1024 lines
        // no idling on either side, including the large sizes
        run_phase(11'd16, 11'd4,  60, 3, 0, 0);
        run_phase(11'd1024, 11'd3, 3 * 1024, 0, 0, 0);
        run_phase(11'd2047, 11'd2047, 3 * 1024 + 10, 0, 0, 0);
        run_phase(11'd3,  11'd1024, 3 * 1024 + 6, 0, 0, 0);
        settle_idle();

        if (mismatches == 0 && filtered_due.size() == 0) begin
            $display("laplacian_edge_filter_rgb_tb passed");
        end else begin
            $display("laplacian_edge_filter_rgb_tb failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("laplacian_edge_filter_rgb_tb failed");
        $finish;
    end

endmodule
